[hw/rtl/gwd_pkg.sv]
// Shared types and constants for the grid wavefront distance map.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package gwd_pkg;

  localparam int MAX_COLS_DEF = 64;
  localparam int MAX_ROWS_DEF = 64;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;
  localparam logic [CFG_W-1:0]     CFG_SIZE_RESET  = 7'd64;

  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_SPREAD = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_NOP    = 2'd3;

  localparam int          OUT_DIST_W   = 12;
  localparam logic [11:0] OUT_DIST_MAX = 12'd4095;

  typedef struct packed {
    logic [1:0] mode;
    logic [5:0] cell_col;
    logic [5:0] cell_row;
    logic       blocked_in;
  } gwd_in_t;

  typedef struct packed {
    logic [OUT_DIST_W-1:0] distance;
    logic                  reached;
    logic                  range_error;
  } gwd_out_t;

  // Write strobes for the grid store.
  typedef struct packed {
    logic wr_dist;
    logic wr_blk;
  } gwd_grid_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/gwd_grid_mem.sv]
// Blocked-flag and distance stores, one write and one registered read a cycle.
// Depends on gwd_pkg for the write strobe struct.
`default_nettype none

module gwd_grid_mem #(
  parameter int AW = 12,
  parameter int DW = 13
) (
  input  wire                     clk,
  input  gwd_pkg::gwd_grid_ctl_t  ctl,
  input  wire  [AW-1:0]           waddr,
  input  wire  [DW-1:0]           wdist,
  input  wire                     wblk,
  input  wire  [AW-1:0]           raddr,
  output logic [DW-1:0]           rdist,
  output logic                    rblk
);
  import gwd_pkg::*;

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] dist_mem [DEPTH];
  logic          blk_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_dist) begin
      dist_mem[waddr] <= wdist;
    end
    if (ctl.wr_blk) begin
      blk_mem[waddr] <= wblk;
    end
    rdist <= dist_mem[raddr];
    rblk  <= blk_mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/gwd_queue_mem.sv]
// Visit queue storage for the spread, one write and one registered read a cycle.
// Imports gwd_pkg; head and tail live in the sequencer.
`default_nettype none

module gwd_queue_mem #(
  parameter int AW = 12
) (
  input  wire           clk,
  input  wire           we,
  input  wire  [AW-1:0] waddr,
  input  wire  [AW-1:0] wdata,
  input  wire  [AW-1:0] raddr,
  output logic [AW-1:0] rdata
);
  import gwd_pkg::*;

  localparam int DEPTH = 1 << AW;

  logic [AW-1:0] q_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      q_mem[waddr] <= wdata;
    end
    rdata <= q_mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/grid_wavefront_distance_map.sv]
// Grid wavefront distance map: blocked-flag grid plus breadth-first distance field.
// Instantiates gwd_grid_mem and gwd_queue_mem; types from gwd_pkg.
//
// Use: one item per transfer on in_*; each item gives exactly one result on out_*.
//   mode 0 writes one cell's blocked flag,
//   mode 2 reads one cell's distance and reached flag,
//   mode 1 runs a spread from the goal cell: a sweep marks every distance
//   unreached, then each queued cell is popped and its neighbours are checked
//   one at a time, since the distance store has a single read port.
// Except in nop mode, an out-of-size cell returns range_error and changes nothing.
// in_stall is high while an item is in work; one item is handled at a time.
// The result sits in an output register; a stalled result holds, and the next
// item is taken meanwhile but its own result waits for the register to free.
// Reset: a clearing pass marks every cell unblocked and unreached, and in_stall
// stays high for it. Configuration writes are taken at any time through cfg_we;
// sizes saturate to 1..MAX_COLS and 1..MAX_ROWS.
`default_nettype none

module grid_wavefront_distance_map #(
  parameter int MAX_COLS = gwd_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = gwd_pkg::MAX_ROWS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  gwd_pkg::gwd_in_t                  in_data,
  output logic                              out_valid,
  input  wire                               out_stall,
  output gwd_pkg::gwd_out_t                 out_data,
  input  wire                               cfg_we,
  input  wire  [gwd_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire  [gwd_pkg::CFG_W-1:0]         cfg_wdata
);
  import gwd_pkg::*;

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int AW = CW + RW;
  localparam int DW = AW + 1;
  localparam logic [DW-1:0] UNR   = {DW{1'b1}};
  localparam logic [AW:0]   LAST  = (AW+1)'((1 << AW) - 1);
  localparam logic [8:0]    MAXC  = 9'(MAX_COLS);
  localparam logic [8:0]    MAXR  = 9'(MAX_ROWS);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLEAR = 4'd1;
  localparam logic [3:0] ST_SEED  = 4'd2;
  localparam logic [3:0] ST_POP   = 4'd3;
  localparam logic [3:0] ST_POPW  = 4'd4;
  localparam logic [3:0] ST_DREAD = 4'd5;
  localparam logic [3:0] ST_NB    = 4'd6;
  localparam logic [3:0] ST_CHK   = 4'd7;
  localparam logic [3:0] ST_WR    = 4'd8;
  localparam logic [3:0] ST_RD    = 4'd9;
  localparam logic [3:0] ST_RDW   = 4'd10;
  localparam logic [3:0] ST_FIN   = 4'd11;

  logic [3:0]      state_r, state_nxt;
  logic            init_r, init_nxt;
  logic [AW:0]     idx_r, idx_nxt;
  logic [AW:0]     head_r, head_nxt;
  logic [AW:0]     tail_r, tail_nxt;
  logic [AW-1:0]   cur_r, cur_nxt;
  logic [AW-1:0]   goal_r, goal_nxt;
  logic [AW-1:0]   nbaddr_r, nbaddr_nxt;
  logic [DW-1:0]   d_r, d_nxt;
  logic [1:0]      nb_r, nb_nxt;
  logic            blk_r, blk_nxt;
  gwd_out_t        res_r, res_nxt;
  logic            out_valid_r, out_valid_nxt;
  gwd_out_t        out_data_r, out_data_nxt;
  logic [CFG_W-1:0] gw_r, gw_nxt, gh_r, gh_nxt;

  logic [8:0]      eff_w, eff_h, col9, row9, c9, r9, nc, nr;
  logic            nb_ok, in_acc, out_free;
  logic [DW+11:0]  dist_wide;

  gwd_grid_ctl_t   g_ctl;
  logic [AW-1:0]   g_waddr, g_raddr, q_waddr, q_raddr, q_wdata, q_rdata;
  logic [DW-1:0]   g_wdist, g_rdist;
  logic            g_wblk, g_rblk, q_we;

  gwd_grid_mem #(.AW(AW), .DW(DW)) u_grid (
    .clk(clk), .ctl(g_ctl), .waddr(g_waddr), .wdist(g_wdist), .wblk(g_wblk),
    .raddr(g_raddr), .rdist(g_rdist), .rblk(g_rblk)
  );

  gwd_queue_mem #(.AW(AW)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  always_comb begin
    eff_w = (gw_r == '0) ? 9'd1 : ((9'(gw_r) > MAXC) ? MAXC : 9'(gw_r));
    eff_h = (gh_r == '0) ? 9'd1 : ((9'(gh_r) > MAXR) ? MAXR : 9'(gh_r));
    col9  = 9'(in_data.cell_col);
    row9  = 9'(in_data.cell_row);
    c9    = 9'(cur_r[CW-1:0]);
    r9    = 9'(cur_r[AW-1:CW]);
    nc    = c9;
    nr    = r9;
    nb_ok = 1'b0;
    unique case (nb_r)
      2'd0: begin nc = c9 + 9'd1; nb_ok = (c9 + 9'd1) < eff_w; end
      2'd1: begin nc = c9 - 9'd1; nb_ok = (c9 != 9'd0); end
      2'd2: begin nr = r9 + 9'd1; nb_ok = (r9 + 9'd1) < eff_h; end
      default: begin nr = r9 - 9'd1; nb_ok = (r9 != 9'd0); end
    endcase
    dist_wide = (DW+12)'(g_rdist);
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    gw_nxt = gw_r;
    gh_nxt = gh_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_GRID_WIDTH:  gw_nxt = cfg_wdata;
        default:         gh_nxt = cfg_wdata;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    init_nxt      = init_r;
    idx_nxt       = idx_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cur_nxt       = cur_r;
    goal_nxt      = goal_r;
    nbaddr_nxt    = nbaddr_r;
    d_nxt         = d_r;
    nb_nxt        = nb_r;
    blk_nxt       = blk_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    g_ctl         = '0;
    g_waddr       = idx_r[AW-1:0];
    g_wdist       = UNR;
    g_wblk        = 1'b0;
    g_raddr       = goal_r;
    q_we          = 1'b0;
    q_waddr       = tail_r[AW-1:0];
    q_wdata       = nbaddr_r;
    q_raddr       = head_r[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          goal_nxt = {row9[RW-1:0], col9[CW-1:0]};
          blk_nxt  = in_data.blocked_in;
          res_nxt  = '0;
          if (in_data.mode == MODE_NOP) begin
            state_nxt = ST_FIN;
          end else if (col9 >= eff_w || row9 >= eff_h) begin
            res_nxt.range_error = 1'b1;
            state_nxt = ST_FIN;
          end else begin
            unique case (in_data.mode)
              MODE_WRITE:  state_nxt = ST_WR;
              MODE_SPREAD: begin state_nxt = ST_CLEAR; idx_nxt = '0; end
              default:     state_nxt = ST_RD;
            endcase
          end
        end
      end
      ST_CLEAR: begin
        g_ctl.wr_dist = 1'b1;
        g_ctl.wr_blk  = init_r;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST) begin
          init_nxt  = 1'b0;
          state_nxt = init_r ? ST_IDLE : ST_SEED;
        end
      end
      ST_SEED: begin
        g_ctl.wr_dist = 1'b1;
        g_waddr  = goal_r;
        g_wdist  = '0;
        q_we     = 1'b1;
        q_waddr  = '0;
        q_wdata  = goal_r;
        head_nxt = '0;
        tail_nxt = (AW+1)'(1);
        state_nxt = ST_POP;
      end
      ST_POP: begin
        state_nxt = (head_r == tail_r) ? ST_FIN : ST_POPW;
      end
      ST_POPW: begin
        cur_nxt   = q_rdata;
        g_raddr   = q_rdata;
        state_nxt = ST_DREAD;
      end
      ST_DREAD: begin
        d_nxt     = g_rdist + 1'b1;
        nb_nxt    = 2'd0;
        state_nxt = ST_NB;
      end
      ST_NB: begin
        if (nb_ok) begin
          g_raddr    = {nr[RW-1:0], nc[CW-1:0]};
          nbaddr_nxt = {nr[RW-1:0], nc[CW-1:0]};
          state_nxt  = ST_CHK;
        end else begin
          nb_nxt = nb_r + 2'd1;
          if (nb_r == 2'd3) begin
            head_nxt  = head_r + 1'b1;
            state_nxt = ST_POP;
          end
        end
      end
      ST_CHK: begin
        if (g_rdist == UNR && !g_rblk) begin
          g_ctl.wr_dist = 1'b1;
          g_waddr  = nbaddr_r;
          g_wdist  = d_r;
          q_we     = 1'b1;
          tail_nxt = tail_r + 1'b1;
        end
        nb_nxt = nb_r + 2'd1;
        if (nb_r == 2'd3) begin
          head_nxt  = head_r + 1'b1;
          state_nxt = ST_POP;
        end else begin
          state_nxt = ST_NB;
        end
      end
      ST_WR: begin
        g_ctl.wr_blk = 1'b1;
        g_waddr   = goal_r;
        g_wblk    = blk_r;
        state_nxt = ST_FIN;
      end
      ST_RD: begin
        state_nxt = ST_RDW;
      end
      ST_RDW: begin
        if (g_rdist != UNR) begin
          res_nxt.reached  = 1'b1;
          res_nxt.distance = (dist_wide > (DW+12)'(OUT_DIST_MAX)) ?
                             OUT_DIST_MAX : dist_wide[11:0];
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      init_r      <= 1'b1;
      idx_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
      gw_r        <= CFG_SIZE_RESET;
      gh_r        <= CFG_SIZE_RESET;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      idx_r       <= idx_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
      gw_r        <= gw_nxt;
      gh_r        <= gh_nxt;
    end
    cur_r      <= cur_nxt;
    goal_r     <= goal_nxt;
    nbaddr_r   <= nbaddr_nxt;
    d_r        <= d_nxt;
    nb_r       <= nb_nxt;
    blk_r      <= blk_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r)
    else $error("queue head passed tail");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r <= LAST + 1'b1)
    else $error("queue tail beyond cell count");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(state_r == ST_FIN))
    else $error("result raised outside finish state");

  a_spread_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.mode == MODE_SPREAD && in_data.cell_col == 6'd0
     && in_data.cell_row == 6'd0) |=> (state_r == ST_CLEAR))
    else $error("spread did not start with clearing sweep");

endmodule

`default_nettype wire

[tb/sv/grid_wavefront_distance_map_test.sv]
// Self-checking bench for grid_wavefront_distance_map: clocked driver and monitor,
// with a breadth-first predictor of the distance field. Depends on gwd_pkg and the block.
`timescale 1ns / 100ps

module grid_wavefront_distance_map_test;
  import gwd_pkg::*;

  localparam int NCOL = 64;
  localparam int NROW = 64;
  localparam int NCELL = NCOL * NROW;
  localparam int UNREACHED = -1;
  localparam longint CYCLE_LIMIT = 20000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  gwd_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  gwd_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_GRID_WIDTH;
  logic [CFG_W-1:0] cfg_wdata = '0;

  grid_wavefront_distance_map i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor state
  logic [CFG_W-1:0] width_reg = CFG_SIZE_RESET;
  logic [CFG_W-1:0] height_reg = CFG_SIZE_RESET;
  bit blocked_grid [NCELL];
  int dist_grid [NCELL];
  int bfs_fifo [NCELL];

  gwd_in_t pending_items[$];
  gwd_out_t expected_results[$];
  int errors = 0;
  bit quiet = 1'b0;
  bit hold_sender = 1'b0;
  bit in_taken = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;
  longint cycle_count = 0;

  function automatic int clamp_size(logic [CFG_W-1:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic void run_wavefront(int col, int row, int w, int h);
    int head, tail, cur, c, r, d, nc, nr, idx;
    for (int i = 0; i < NCELL; i++) dist_grid[i] = UNREACHED;
    head = 0;
    tail = 0;
    dist_grid[row * NCOL + col] = 0;
    bfs_fifo[tail++] = row * NCOL + col;
    while (head < tail) begin
      cur = bfs_fifo[head++];
      c = cur % NCOL;
      r = cur / NCOL;
      d = dist_grid[cur] + 1;
      // neighbour order +col, -col, +row, -row
      for (int k = 0; k < 4; k++) begin
        nc = c + (k == 0 ? 1 : k == 1 ? -1 : 0);
        nr = r + (k == 2 ? 1 : k == 3 ? -1 : 0);
        if (nc >= 0 && nr >= 0 && nc < w && nr < h) begin
          idx = nr * NCOL + nc;
          if (dist_grid[idx] == UNREACHED && !blocked_grid[idx]) begin
            dist_grid[idx] = d;
            if (tail < NCELL) bfs_fifo[tail++] = idx;
          end
        end
      end
    end
  endfunction

  function automatic gwd_out_t predict_cell_op(gwd_in_t it);
    gwd_out_t res;
    int w, h, idx;
    res = '0;
    w = clamp_size(width_reg, NCOL);
    h = clamp_size(height_reg, NROW);
    idx = int'(it.cell_row) * NCOL + int'(it.cell_col);
    if (it.mode == MODE_NOP) return res;
    if (it.cell_col >= w || it.cell_row >= h) begin
      res.range_error = 1'b1;
      return res;
    end
    case (it.mode)
      MODE_WRITE: blocked_grid[idx] = it.blocked_in;
      MODE_SPREAD: run_wavefront(it.cell_col, it.cell_row, w, h);
      default: begin
        if (dist_grid[idx] != UNREACHED) begin
          res.reached = 1'b1;
          res.distance = dist_grid[idx] > 4095 ? OUT_DIST_MAX : dist_grid[idx][11:0];
        end
      end
    endcase
    return res;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      // advance once the presented item has been transferred
      if (!in_valid || in_taken) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0 && !hold_sender) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 9);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(0, 8);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor and predictor update
  always @(posedge clk) begin
    gwd_out_t want;
    cycle_count <= cycle_count + 1;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) expected_results.push_back(predict_cell_op(in_data));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.distance !== want.distance) begin
            $error("distance expected %0d got %0d", want.distance, out_data.distance);
            errors++;
          end
          if (out_data.reached !== want.reached) begin
            $error("reached expected %0d got %0d", want.reached, out_data.reached);
            errors++;
          end
          if (out_data.range_error !== want.range_error) begin
            $error("range_error expected %0d got %0d", want.range_error,
                   out_data.range_error);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic gwd_in_t make_item(logic [1:0] m, int c, int r, bit b);
    gwd_in_t it;
    it.mode = m;
    it.cell_col = c[5:0];
    it.cell_row = r[5:0];
    it.blocked_in = b;
    return it;
  endfunction

  function automatic gwd_in_t random_item(int w, int h);
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 9) return make_item(MODE_WRITE, $urandom_range(0, w - 1),
                                  $urandom_range(0, h - 1), $urandom_range(0, 3) == 0);
    if (sel < 10) return make_item(MODE_SPREAD, $urandom_range(0, w - 1),
                                   $urandom_range(0, h - 1), 1'($urandom_range(0, 1)));
    if (sel < 17) return make_item(MODE_READ, $urandom_range(0, w - 1),
                                   $urandom_range(0, h - 1), 1'($urandom_range(0, 1)));
    // noise: any field value, nop included
    return make_item(2'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom_range(0, 63),
                     1'($urandom_range(0, 1)));
  endfunction

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    // idle margin after the last result
    repeat (60000) @(posedge clk);
  endtask

  task automatic write_size(logic [CFG_IDX_W-1:0] which, logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= which;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (which == CFG_GRID_WIDTH) width_reg = v;
    else height_reg = v;
  endtask

  initial begin
    logic [CFG_W-1:0] widths [5];
    logic [CFG_W-1:0] heights [5];
    for (int i = 0; i < NCELL; i++) begin
      blocked_grid[i] = 1'b0;
      dist_grid[i] = UNREACHED;
    end
    widths = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd5};
    heights = '{7'd64, 7'd1, 7'd100, 7'd0, 7'd6};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every mode, blocked goal, nop
    pending_items.push_back(make_item(MODE_READ, 0, 0, 0));
    pending_items.push_back(make_item(MODE_WRITE, 63, 63, 1));
    pending_items.push_back(make_item(MODE_WRITE, 1, 0, 1));
    pending_items.push_back(make_item(MODE_WRITE, 0, 1, 1));
    pending_items.push_back(make_item(MODE_SPREAD, 63, 63, 0));
    pending_items.push_back(make_item(MODE_READ, 63, 63, 1));
    pending_items.push_back(make_item(MODE_READ, 0, 0, 0));
    pending_items.push_back(make_item(MODE_READ, 62, 63, 0));
    pending_items.push_back(make_item(MODE_SPREAD, 0, 0, 1));
    pending_items.push_back(make_item(MODE_READ, 0, 0, 0));
    pending_items.push_back(make_item(MODE_READ, 5, 5, 0));
    pending_items.push_back(make_item(MODE_WRITE, 1, 0, 0));
    pending_items.push_back(make_item(MODE_NOP, 63, 63, 1));
    pending_items.push_back(make_item(MODE_SPREAD, 0, 0, 0));
    pending_items.push_back(make_item(MODE_READ, 63, 0, 1));
    pending_items.push_back(make_item(MODE_READ, 63, 62, 1));
    drain();

    write_size(CFG_GRID_WIDTH, 7'd8);
    write_size(CFG_GRID_HEIGHT, 7'd4);
    pending_items.push_back(make_item(MODE_WRITE, 8, 0, 1));
    pending_items.push_back(make_item(MODE_SPREAD, 0, 4, 0));
    pending_items.push_back(make_item(MODE_READ, 63, 63, 0));
    pending_items.push_back(make_item(MODE_SPREAD, 7, 3, 0));
    pending_items.push_back(make_item(MODE_READ, 0, 0, 0));
    pending_items.push_back(make_item(MODE_READ, 63, 0, 0));
    // sender waits for every result before going on
    while (pending_items.size() > 0 || in_valid) @(posedge clk);
    hold_sender = 1'b1;
    while (expected_results.size() > 0) @(posedge clk);
    pending_items.push_back(make_item(MODE_READ, 7, 0, 0));
    hold_sender = 1'b0;
    drain();

    // random phases over several sizes
    for (int p = 0; p < 5; p++) begin
      int w, h;
      write_size(CFG_GRID_WIDTH, widths[p]);
      write_size(CFG_GRID_HEIGHT, heights[p]);
      w = clamp_size(widths[p], NCOL);
      h = clamp_size(heights[p], NROW);
      if (p == 4) quiet = 1'b1;
      for (int n = 0; n < 20; n++) pending_items.push_back(random_item(w, h));
      drain();
    end

    if (errors == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
